// File: rtl/lin_master_frame_builder_macros.svh
// Assertion macros used by the frame builder top level.
`ifndef LIN_MASTER_FRAME_BUILDER_MACROS_SVH
`define LIN_MASTER_FRAME_BUILDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LMFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmfb assertion failed");

// next-cycle implication, disabled while in reset
`define LMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmfb assertion failed");

`endif

// File: rtl/lmfb_pkg.sv
// Types, constants and parity function of the LIN master frame builder.
package lmfb_pkg;

  localparam logic [7:0] LIN_SYNC     = 8'h55;
  localparam logic [5:0] ID_CLASSIC_A = 6'h3C;
  localparam logic [5:0] ID_CLASSIC_B = 6'h3D;

  typedef struct packed {
    logic [5:0] frame_id;
    logic [3:0] data_count;
    logic [7:0] data_byte_0;
    logic [7:0] data_byte_1;
    logic [7:0] data_byte_2;
    logic [7:0] data_byte_3;
    logic [7:0] data_byte_4;
    logic [7:0] data_byte_5;
    logic [7:0] data_byte_6;
    logic [7:0] data_byte_7;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       is_break;
    logic       is_last;
  } out_item_t;

  // classified frame header handed from front to back
  typedef struct packed {
    logic [7:0] pid;
    logic       classic;
    logic [3:0] count;
  } frame_ctl_t;

  function automatic logic [7:0] protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

// File: rtl/lin_master_frame_builder.sv
// Top level of the LIN master frame builder: front end, frame queue, back end.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   input   | in_push, in_full, in_item      | one frame request per item
//   result  | out_pop, out_empty, out_item   | one line item (break/byte) each
//
// A frame of N data bytes gives N + 4 line items, one per cycle from the back
// end sequencer unless a stalled out_pop holds it; that sequencer sets the frame rate.
// Requests are taken every cycle while the two-entry frame queue has room.
// A stalled out_pop holds the result register and backs up into the queue.
// Reset (rst_n low, synchronous) empties the queue and the result register.
`include "lin_master_frame_builder_macros.svh"

module lin_master_frame_builder
  import lmfb_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  frame_ctl_t                     f_ctl;
  logic [MAX_DATA_BYTES-1:0][7:0] f_data;
  frame_ctl_t                     q_ctl;
  logic [MAX_DATA_BYTES-1:0][7:0] q_data;
  logic                           q_valid;
  logic                           q_pop;

  lmfb_front #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_front (
    .in_item (in_item),
    .ctl     (f_ctl),
    .data    (f_data)
  );

  lmfb_fifo #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_ctl  (f_ctl),
    .wr_data (f_data),
    .full    (in_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_ctl  (q_ctl),
    .rd_data (q_data)
  );

  lmfb_back #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  `LMFB_ASSERT_NOW(a_break_shape, clk, rst_n, !out_empty && out_item.is_break, !out_item.is_last && (out_item.line_byte == 8'h00))
  `LMFB_ASSERT_NEXT(a_sync_after_break, clk, rst_n, out_pop && !out_empty && out_item.is_break, !out_empty && !out_item.is_break && (out_item.line_byte == LIN_SYNC))
  `LMFB_ASSERT_NEXT(a_break_after_last, clk, rst_n, out_pop && !out_empty && out_item.is_last, out_empty || out_item.is_break)

endmodule

// File: rtl/lmfb_front.sv
// Front end: protects the identifier, picks the checksum type, clamps the count.
module lmfb_front
  import lmfb_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 8
) (
  input  in_item_t                            in_item,
  output frame_ctl_t                          ctl,
  output logic [MAX_DATA_BYTES-1:0][7:0]      data
);

  logic [7:0][7:0] all_bytes;

  assign all_bytes = {in_item.data_byte_7, in_item.data_byte_6, in_item.data_byte_5,
                      in_item.data_byte_4, in_item.data_byte_3, in_item.data_byte_2,
                      in_item.data_byte_1, in_item.data_byte_0};

  always_comb begin
    ctl.pid     = protect_id(in_item.frame_id);
    ctl.classic = (in_item.frame_id == ID_CLASSIC_A) || (in_item.frame_id == ID_CLASSIC_B);
    if (in_item.data_count > 4'(MAX_DATA_BYTES)) begin
      ctl.count = 4'(MAX_DATA_BYTES);
    end else begin
      ctl.count = in_item.data_count;
    end
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      data[i] = all_bytes[i];
    end
  end

endmodule

// File: rtl/lmfb_fifo.sv
// Two-entry queue of classified frames between front and back.
module lmfb_fifo
  import lmfb_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  frame_ctl_t                         wr_ctl,
  input  logic [MAX_DATA_BYTES-1:0][7:0]     wr_data,
  output logic                               full,
  input  logic                               pop,
  output logic                               valid,
  output frame_ctl_t                         rd_ctl,
  output logic [MAX_DATA_BYTES-1:0][7:0]     rd_data
);

  frame_ctl_t                     ctl_r  [2];
  logic [MAX_DATA_BYTES-1:0][7:0] data_r [2];
  logic                           wr_ptr_r;
  logic                           rd_ptr_r;
  logic [1:0]                     cnt_r;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_ctl  = ctl_r[rd_ptr_r];
  assign rd_data = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_r[wr_ptr_r]  <= wr_ctl;
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/lmfb_back.sv
// Back end: sequences the line items of one frame and accumulates the checksum.
module lmfb_back
  import lmfb_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  frame_ctl_t                         q_ctl,
  input  logic [MAX_DATA_BYTES-1:0][7:0]     q_data,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output out_item_t                          out_item
);

  localparam int DIDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  typedef enum logic {IDLE, RUN} state_t;

  state_t                         state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  out_item_t                      out_item_r, out_item_nxt;
  logic [3:0]                     step_r, step_nxt;
  logic [7:0]                     pid_r, pid_nxt;
  logic [3:0]                     count_r, count_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic [MAX_DATA_BYTES-1:0][7:0] data_r, data_nxt;
  logic                           adv;
  logic [3:0]                     last_step;
  logic [DIDX_W-1:0]              didx;
  logic [7:0]                     cur_byte;
  logic [8:0]                     sum9;

  assign adv       = !out_valid_r || out_pop;
  assign last_step = count_r + 4'd3;
  assign didx      = DIDX_W'(step_r - 4'd3);
  assign cur_byte  = data_r[didx];
  assign sum9      = {1'b0, sum_r} + {1'b0, cur_byte};
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    step_nxt      = step_r;
    pid_nxt       = pid_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    data_nxt      = data_r;
    q_pop         = 1'b0;
    if (adv) begin
      unique case (state_r)
        IDLE: begin
          out_valid_nxt = q_valid;
          if (q_valid) begin
            q_pop        = 1'b1;
            out_item_nxt = '{line_byte: 8'h00, is_break: 1'b1, is_last: 1'b0};
            pid_nxt      = q_ctl.pid;
            count_nxt    = q_ctl.count;
            data_nxt     = q_data;
            sum_nxt      = q_ctl.classic ? 8'h00 : q_ctl.pid;
            step_nxt     = 4'd1;
            state_nxt    = RUN;
          end
        end
        RUN: begin
          out_valid_nxt = 1'b1;
          step_nxt      = step_r + 4'd1;
          if (step_r == 4'd1) begin
            out_item_nxt = '{line_byte: LIN_SYNC, is_break: 1'b0, is_last: 1'b0};
          end else if (step_r == 4'd2) begin
            out_item_nxt = '{line_byte: pid_r, is_break: 1'b0, is_last: 1'b0};
          end else if (step_r < last_step) begin
            out_item_nxt = '{line_byte: cur_byte, is_break: 1'b0, is_last: 1'b0};
            // end-around carry
            sum_nxt      = sum9[7:0] + {7'd0, sum9[8]};
          end else begin
            out_item_nxt = '{line_byte: ~sum_r, is_break: 1'b0, is_last: 1'b1};
            state_nxt    = IDLE;
          end
        end
        default: state_nxt = IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
    step_r     <= step_nxt;
    pid_r      <= pid_nxt;
    count_r    <= count_nxt;
    sum_r      <= sum_nxt;
    data_r     <= data_nxt;
  end

endmodule

// File: tb/sv/tb_lin_master_frame_builder.sv
// Testbench for lin_master_frame_builder: directed frame table, random frames, scoreboard.
`timescale 1ns / 100ps

module tb_lin_master_frame_builder;
  import lmfb_pkg::*;

  localparam int MAX_BYTES     = 8;
  localparam int RANDOM_FRAMES = 292;
  localparam int IDLE_PCT      = 34;

  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [7:0] pid;
    logic [7:0] chk;
  } frame_row_t;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      in_push  = 1'b0;
  in_item_t  in_item  = '0;
  logic      out_pop  = 1'b0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_item;

  out_item_t line_items_due[$];
  int        error_count = 0;
  bit        steady      = 1'b0;

  lin_master_frame_builder #(
    .MAX_DATA_BYTES(MAX_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] data_at(input in_item_t it, input int i);
    case (i)
      0: return it.data_byte_0;
      1: return it.data_byte_1;
      2: return it.data_byte_2;
      3: return it.data_byte_3;
      4: return it.data_byte_4;
      5: return it.data_byte_5;
      6: return it.data_byte_6;
      default: return it.data_byte_7;
    endcase
  endfunction

  function automatic int frame_len(input in_item_t it);
    return (int'(it.data_count) > MAX_BYTES) ? MAX_BYTES : int'(it.data_count);
  endfunction

  // break, sync, protected id, data bytes, checksum
  task automatic queue_frame(input in_item_t it, input logic [7:0] pid, input logic [7:0] chk);
    out_item_t li;
    li = '{line_byte: 8'h00, is_break: 1'b1, is_last: 1'b0};
    line_items_due.push_back(li);
    li = '{line_byte: LIN_SYNC, is_break: 1'b0, is_last: 1'b0};
    line_items_due.push_back(li);
    li.line_byte = pid;
    line_items_due.push_back(li);
    for (int i = 0; i < frame_len(it); i++) begin
      li.line_byte = data_at(it, i);
      line_items_due.push_back(li);
    end
    li = '{line_byte: chk, is_break: 1'b0, is_last: 1'b1};
    line_items_due.push_back(li);
  endtask

  task automatic predict_frame(input in_item_t it);
    logic [7:0] pid;
    int         sum;
    pid = {~^(it.frame_id & 6'b111010), ^(it.frame_id & 6'b010111), it.frame_id};
    if (it.frame_id == ID_CLASSIC_A || it.frame_id == ID_CLASSIC_B) begin
      sum = 0;
    end else begin
      sum = int'(pid);
    end
    for (int i = 0; i < frame_len(it); i++) begin
      sum = sum + int'(data_at(it, i));
      if (sum > 255) begin
        sum = sum - 255;
      end
    end
    queue_frame(it, pid, ~sum[7:0]);
  endtask

  task automatic send_frame(input in_item_t it, input bit typed, input logic [7:0] pid,
                            input logic [7:0] chk);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PCT && gap < 8) begin
      gap++;
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (typed) begin
      queue_frame(it, pid, chk);
    end else begin
      predict_frame(it);
    end
  endtask

  task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_item_t exp_li;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (line_items_due.size() == 0) begin
          $display("%0t: unexpected line item, actual %h brk %b last %b", $time,
                   out_item.line_byte, out_item.is_break, out_item.is_last);
          error_count++;
        end else begin
          exp_li = line_items_due.pop_front();
          if (out_item.line_byte !== exp_li.line_byte) begin
            report("line_byte", exp_li.line_byte, out_item.line_byte);
          end
          if (out_item.is_break !== exp_li.is_break) begin
            report("is_break", exp_li.is_break, out_item.is_break);
          end
          if (out_item.is_last !== exp_li.is_last) begin
            report("is_last", exp_li.is_last, out_item.is_last);
          end
        end
      end
      out_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    frame_row_t dir_rows[18];
    in_item_t   it;
    logic [5:0] id;
    logic [3:0] cnt;

    // pid/checksum typed in where they follow directly from the id and bytes
    dir_rows = '{
      '{{6'h00, 4'd0,  64'h0000_0000_0000_0000}, 1'b1, 8'h80, 8'h7F},
      '{{6'h3F, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 8'hBF, 8'h40},
      '{{6'h3C, 4'd0,  64'h1234_5678_9ABC_DEF0}, 1'b1, 8'h3C, 8'hFF},
      '{{6'h3D, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 8'h7D, 8'hFF},
      '{{6'h3C, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 8'h3C, 8'h00},
      '{{6'h3D, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 8'h7D, 8'h00},
      '{{6'h00, 4'd8,  64'h0000_0000_0000_0000}, 1'b1, 8'h80, 8'h7F},
      '{{6'h3F, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 8'hBF, 8'h40},
      '{{6'h2A, 4'd3,  64'h11_22_33_FF_FF_FF_FF_FF}, 1'b0, 8'h00, 8'h00},
      '{{6'h15, 4'd9,  64'h80_81_82_83_84_85_86_87}, 1'b0, 8'h00, 8'h00},
      '{{6'h3C, 4'd4,  64'hF0_E1_D2_C3_A5_A5_A5_A5}, 1'b0, 8'h00, 8'h00},
      '{{6'h01, 4'd1,  64'h7F_FF_FF_FF_FF_FF_FF_FF}, 1'b0, 8'h00, 8'h00},
      '{{6'h12, 4'd2,  64'hFE_FE_01_01_01_01_01_01}, 1'b0, 8'h00, 8'h00},
      '{{6'h3E, 4'd12, 64'hDE_AD_BE_EF_CA_FE_F0_0D}, 1'b0, 8'h00, 8'h00},
      '{{6'h3B, 4'd5,  64'h01_02_04_08_10_00_00_00}, 1'b0, 8'h00, 8'h00},
      '{{6'h20, 4'd7,  64'hAA_55_AA_55_AA_55_AA_33}, 1'b0, 8'h00, 8'h00},
      '{{6'h10, 4'd6,  64'h20_40_60_80_A0_C0_E0_FF}, 1'b0, 8'h00, 8'h00},
      '{{6'h0F, 4'd8,  64'h01_23_45_67_89_AB_CD_EF}, 1'b0, 8'h00, 8'h00}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_frame(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].pid, dir_rows[r].chk);
    end

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      steady = (n >= 120 && n < 200);
      if ($urandom_range(99) < 15) begin
        id = $urandom_range(1) ? ID_CLASSIC_A : ID_CLASSIC_B;
      end else begin
        id = 6'($urandom_range(63));
      end
      if ($urandom_range(99) < 12) begin
        cnt = 4'($urandom_range(15, 9));
      end else begin
        cnt = 4'($urandom_range(MAX_BYTES));
      end
      it = {id, cnt, $urandom, $urandom};
      send_frame(it, 1'b0, 8'h00, 8'h00);
    end
    steady = 1'b0;
    in_push <= 1'b0;

    while (line_items_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (line_items_due.size() != 0) begin
      $display("%0t: %0d line items never arrived", $time, line_items_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** lin_master_frame_builder: PASSED **");
    end else begin
      $display("** lin_master_frame_builder: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d line items outstanding", $time, line_items_due.size());
    $display("** lin_master_frame_builder: FAILED **");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lmfb_pkg.sv
rtl/lmfb_front.sv
rtl/lmfb_fifo.sv
rtl/lmfb_back.sv
rtl/lin_master_frame_builder.sv
tb/sv/tb_lin_master_frame_builder.sv
